// File: hdl/cdt_pkg.sv
package cdt_pkg;

   localparam int TIME_BITS = 12;
   localparam int CSR_BITS  = 12;
   localparam int AMT_BITS  = 9;
   localparam int OP_BITS   = 3;
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);

   // Incoming command codes
   localparam logic [3:0] REQ_TICK    = 4'd0;
   localparam logic [3:0] REQ_START   = 4'd1;
   localparam logic [3:0] REQ_STOP    = 4'd2;
   localparam logic [3:0] REQ_TOGGLE  = 4'd3;
   localparam logic [3:0] REQ_RELOAD  = 4'd4;
   localparam logic [3:0] REQ_ADD1    = 4'd5;
   localparam logic [3:0] REQ_SUB1    = 4'd6;
   localparam logic [3:0] REQ_ADD5    = 4'd7;
   localparam logic [3:0] REQ_SUB5    = 4'd8;

   // Classified operations
   localparam logic [OP_BITS-1:0] OP_NOP    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_TICK   = 3'd1;
   localparam logic [OP_BITS-1:0] OP_START  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_STOP   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_TOGGLE = 3'd4;
   localparam logic [OP_BITS-1:0] OP_RELOAD = 3'd5;
   localparam logic [OP_BITS-1:0] OP_ADD    = 3'd6;
   localparam logic [OP_BITS-1:0] OP_SUB    = 3'd7;

   localparam logic [AMT_BITS-1:0] ONE_MIN_SECS  = 9'd60;
   localparam logic [AMT_BITS-1:0] FIVE_MIN_SECS = 9'd300;

   localparam logic [TIME_BITS-1:0] HOUR_SECS     = 12'd3600;
   localparam logic [TIME_BITS-1:0] START_DEFAULT = 12'd300;
   localparam logic [TIME_BITS-1:0] MAX_DEFAULT   = 12'd3600;

   // floor(x * 2185 / 2^17) == floor(x / 60) for x < 3600
   localparam logic [11:0] RECIP_60    = 12'd2185;
   localparam int          RECIP_SHIFT = 17;
   localparam int          PROD_BITS   = 24;

   localparam logic [11:0] DISPLAY_NONE = 12'hFFF;

   localparam logic CSR_START = 1'b0;
   localparam logic CSR_MAX   = 1'b1;

   typedef struct packed {
      logic [OP_BITS-1:0]  op;
      logic [AMT_BITS-1:0] amount;
   } cmd_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] start_seconds;
      logic [TIME_BITS-1:0] max_seconds;
   } cfg_type;

endpackage

// File: hdl/cdt_front.sv
module cdt_front
   import cdt_pkg::*;
(
   input  logic [3:0] req_type,
   input  logic [7:0] req_seconds_elapsed,
   output cmd_type    cmd
);

   always_comb begin
      cmd.op     = OP_NOP;
      cmd.amount = '0;
      case (req_type)
         REQ_TICK: begin
            cmd.op     = OP_TICK;
            cmd.amount = {1'b0, req_seconds_elapsed};
         end
         REQ_START:  cmd.op = OP_START;
         REQ_STOP:   cmd.op = OP_STOP;
         REQ_TOGGLE: cmd.op = OP_TOGGLE;
         REQ_RELOAD: cmd.op = OP_RELOAD;
         REQ_ADD1: begin
            cmd.op     = OP_ADD;
            cmd.amount = ONE_MIN_SECS;
         end
         REQ_SUB1: begin
            cmd.op     = OP_SUB;
            cmd.amount = ONE_MIN_SECS;
         end
         REQ_ADD5: begin
            cmd.op     = OP_ADD;
            cmd.amount = FIVE_MIN_SECS;
         end
         REQ_SUB5: begin
            cmd.op     = OP_SUB;
            cmd.amount = FIVE_MIN_SECS;
         end
         default: begin
            cmd.op     = OP_NOP;
            cmd.amount = '0;
         end
      endcase
   end

endmodule

// File: hdl/cdt_fifo.sv
module cdt_fifo
   import cdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   cmd_type                mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QPTR_BITS+1)'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/cdt_back.sv
module cdt_back
   import cdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_empty,
   input  cmd_type    q_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_minutes_shown,
   output logic [5:0] rsp_seconds_shown,
   output logic       rsp_running,
   output logic       rsp_display_changed
);

   logic                  advance;

   // timer state
   logic [TIME_BITS-1:0]  remaining_ff, remaining_in;
   logic                  active_ff, active_in;

   // execute stage
   logic                  v1_ff;
   logic [TIME_BITS-1:0]  rem1_ff;
   logic                  act1_ff;

   // reduce stage
   logic                  v2_ff;
   logic [TIME_BITS-1:0]  xm2_ff;
   logic [PROD_BITS-1:0]  prod2_ff;
   logic                  act2_ff;

   // output stage
   logic                  rsp_valid_ff;
   logic [5:0]            mins_ff, secs_ff;
   logic                  running_ff, changed_ff;
   logic [11:0]           last_display_ff;

   logic [TIME_BITS:0]    sum;
   logic [TIME_BITS-1:0]  tick_left;
   logic [TIME_BITS-1:0]  xm;
   logic [5:0]            q;
   logic [TIME_BITS-1:0]  rem60;
   logic [11:0]           shown;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_pop   = advance && !q_empty;

   always_comb begin
      remaining_in = remaining_ff;
      active_in    = active_ff;
      sum          = {1'b0, remaining_ff} + (TIME_BITS+1)'(q_data.amount);
      tick_left    = ((TIME_BITS)'(q_data.amount) >= remaining_ff) ? '0
                   : remaining_ff - (TIME_BITS)'(q_data.amount);
      case (q_data.op)
         OP_TICK: begin
            if (active_ff) begin
               if (tick_left == '0) begin
                  remaining_in = cfg.start_seconds;
                  active_in    = 1'b0;
               end else begin
                  remaining_in = tick_left;
               end
            end
         end
         OP_START:  active_in = 1'b1;
         OP_STOP:   active_in = 1'b0;
         OP_TOGGLE: active_in = !active_ff;
         OP_RELOAD: begin
            remaining_in = cfg.start_seconds;
            active_in    = 1'b0;
         end
         OP_ADD: begin
            if (!sum[TIME_BITS] && (sum[TIME_BITS-1:0] <= cfg.max_seconds)) begin
               remaining_in = sum[TIME_BITS-1:0];
            end
         end
         OP_SUB: begin
            if (remaining_ff >= (TIME_BITS)'(q_data.amount)) begin
               remaining_in = remaining_ff - (TIME_BITS)'(q_data.amount);
            end
         end
         default: ;
      endcase
   end

   // remaining mod one hour
   assign xm = (rem1_ff >= HOUR_SECS) ? rem1_ff - HOUR_SECS : rem1_ff;

   assign q     = prod2_ff[RECIP_SHIFT +: 6];
   assign rem60 = xm2_ff - ((TIME_BITS)'(q) << 6) + ((TIME_BITS)'(q) << 2);
   assign shown = {q, rem60[5:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff    <= START_DEFAULT;
         active_ff       <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         last_display_ff <= DISPLAY_NONE;
      end else if (advance) begin
         if (q_pop) begin
            remaining_ff <= remaining_in;
            active_ff    <= active_in;
         end
         v1_ff        <= q_pop;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
         if (v2_ff) begin
            last_display_ff <= shown;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem1_ff    <= remaining_in;
         act1_ff    <= active_in;
         xm2_ff     <= xm;
         prod2_ff   <= PROD_BITS'(xm) * PROD_BITS'(RECIP_60);
         act2_ff    <= act1_ff;
         mins_ff    <= q;
         secs_ff    <= rem60[5:0];
         running_ff <= act2_ff;
         changed_ff <= (shown != last_display_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_minutes_shown   = mins_ff;
   assign rsp_seconds_shown   = secs_ff;
   assign rsp_running         = running_ff;
   assign rsp_display_changed = changed_ff;

endmodule

// File: hdl/countdown_timer_with_adjust_top.sv
// Countdown timer with minute adjust. One transaction per clock is taken in sustained
// operation while the result side does not stall; each gives exactly one result.
// Commands are decoded and held in a four-entry queue, then the back end updates the
// timer and converts the time to minutes and seconds over two further stages (hour
// wrap and reciprocal multiply, then remainder). A stalled result stops the back end;
// the queue keeps taking transactions until it is full. Registers are written through
// the csr_ port only while idle; the user must ensure this, as the block does not.
module countdown_timer_with_adjust_top
   import cdt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_type,
   input  logic [7:0]          req_seconds_elapsed,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [5:0]          rsp_minutes_shown,
   output logic [5:0]          rsp_seconds_shown,
   output logic                rsp_running,
   output logic                rsp_display_changed,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata
);

   cfg_type cfg_ff;
   cmd_type front_cmd;
   cmd_type q_data;
   logic    q_full, q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_seconds <= START_DEFAULT;
         cfg_ff.max_seconds   <= MAX_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START: cfg_ff.start_seconds <= csr_wdata;
            CSR_MAX:   cfg_ff.max_seconds   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !q_full;

   cdt_front u_front (
      .req_type            (req_type),
      .req_seconds_elapsed (req_seconds_elapsed),
      .cmd                 (front_cmd)
   );

   cdt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   cdt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_empty             (q_empty),
      .q_data              (q_data),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_minutes_shown   (rsp_minutes_shown),
      .rsp_seconds_shown   (rsp_seconds_shown),
      .rsp_running         (rsp_running),
      .rsp_display_changed (rsp_display_changed)
   );

   a_display_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minutes_shown < 6'd60) && (rsp_seconds_shown < 6'd60))
      else $error("display out of range");

   a_csr_start : assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_START) |=> cfg_ff.start_seconds == $past(csr_wdata))
      else $error("start register not written");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running)
         && $stable(rsp_display_changed))
      else $error("result changed while stalled");

endmodule

// File: verif/countdown_timer_check.sv
module countdown_timer_check
   import cdt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [3:0]          req_type,
   input  logic [7:0]          req_seconds_elapsed,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [5:0]          rsp_minutes_shown,
   input  logic [5:0]          rsp_seconds_shown,
   input  logic                rsp_running,
   input  logic                rsp_display_changed,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata,
   output int                  fail_count,
   output int                  displays_owed,
   output int                  results_seen
);

   typedef struct packed {
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       running;
      logic       changed;
   } display_t;

   localparam int unsigned TIME_LIMIT = (1 << TIME_BITS) - 1;

   logic [CSR_BITS-1:0]  reload_secs;
   logic [CSR_BITS-1:0]  ceiling_secs;
   logic [TIME_BITS-1:0] secs_left;
   logic                 counting;
   logic [11:0]          prev_shown;
   display_t             pending_displays[$];

   task automatic advance_timer(input logic [3:0] code, input logic [7:0] elapsed,
                                output display_t d);
      int unsigned rem;
      int unsigned sum;
      int unsigned amt;
      int unsigned mins;
      int unsigned secs;
      logic [11:0] shown;
      rem = secs_left;
      case (code)
         REQ_TICK: begin
            if (counting) begin
               rem = (elapsed >= rem) ? 0 : rem - elapsed;
               if (rem == 0) begin
                  counting = 1'b0;
                  rem      = reload_secs & TIME_LIMIT;
               end
            end
         end
         REQ_START:  counting = 1'b1;
         REQ_STOP:   counting = 1'b0;
         REQ_TOGGLE: counting = !counting;
         REQ_RELOAD: begin
            counting = 1'b0;
            rem      = reload_secs & TIME_LIMIT;
         end
         REQ_ADD1, REQ_ADD5: begin
            amt = (code == REQ_ADD1) ? ONE_MIN_SECS : FIVE_MIN_SECS;
            sum = rem + amt;
            if (sum <= ceiling_secs && sum <= TIME_LIMIT) rem = sum;
         end
         REQ_SUB1, REQ_SUB5: begin
            amt = (code == REQ_SUB1) ? ONE_MIN_SECS : FIVE_MIN_SECS;
            if (rem >= amt) rem = rem - amt;
         end
         default: ;
      endcase
      mins  = (rem % HOUR_SECS) / ONE_MIN_SECS;
      secs  = rem % ONE_MIN_SECS;
      shown = {mins[5:0], secs[5:0]};
      d.minutes  = mins[5:0];
      d.seconds  = secs[5:0];
      d.running  = counting;
      d.changed  = (shown != prev_shown);
      prev_shown = shown;
      secs_left  = rem[TIME_BITS-1:0];
   endtask

   function automatic void check_field(string field, logic [5:0] want, logic [5:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      display_t want;
      if (reset) begin
         reload_secs  = START_DEFAULT;
         ceiling_secs = MAX_DEFAULT;
         secs_left    = START_DEFAULT;
         counting     = 1'b0;
         prev_shown   = DISPLAY_NONE;
         fail_count   = 0;
         results_seen = 0;
         pending_displays.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_START) reload_secs = csr_wdata;
            else ceiling_secs = csr_wdata;
         end
         if (req_valid && req_ready) begin
            advance_timer(req_type, req_seconds_elapsed, want);
            pending_displays.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_displays.size() == 0) begin
               $error("unexpected result transaction: %0d:%0d running %0b",
                      rsp_minutes_shown, rsp_seconds_shown, rsp_running);
               fail_count++;
            end else begin
               want = pending_displays.pop_front();
               check_field("minutes_shown", want.minutes, rsp_minutes_shown);
               check_field("seconds_shown", want.seconds, rsp_seconds_shown);
               check_field("running", 6'(want.running), 6'(rsp_running));
               check_field("display_changed", 6'(want.changed),
                           6'(rsp_display_changed));
            end
         end
      end
      displays_owed = pending_displays.size();
   end

endmodule

// File: verif/tb_countdown_timer_with_adjust_top.sv
module tb_countdown_timer_with_adjust_top;
   import cdt_pkg::*;

   localparam logic [3:0] REQ_UNKNOWN_LO = 4'd9;
   localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [3:0]          req_type = REQ_TICK;
   logic [7:0]          req_seconds_elapsed = 8'd0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [5:0]          rsp_minutes_shown;
   logic [5:0]          rsp_seconds_shown;
   logic                rsp_running;
   logic                rsp_display_changed;
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_START;
   logic [CSR_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int displays_owed;
   int results_seen;
   int send_idle = 0;
   int recv_stall = 0;
   int hold_left = 0;
   int items_sent = 0;
   int csr_writes = 0;
   int drain_fail = 0;

   countdown_timer_with_adjust_top dut (.*);

   countdown_timer_check check (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 400000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: long hold-off when requested, otherwise random stalls
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
         end
      end
   end

   task automatic send(input logic [3:0] code, input logic [7:0] elapsed);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= code;
      req_seconds_elapsed <= elapsed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (displays_owed != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (displays_owed != 0) begin
         $error("%0d result transactions never arrived", displays_owed);
         drain_fail++;
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_BITS-1:0] start_val,
                             input logic [CSR_BITS-1:0] max_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_START;
      csr_wdata <= start_val;
      @(posedge clock);
      csr_index <= CSR_MAX;
      csr_wdata <= max_val;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_writes += 2;
   endtask

   task automatic run_phase(input int count, input int idle, input int stall);
      int r;
      logic [3:0] code;
      logic [7:0] elapsed;
      send_idle  = idle;
      recv_stall = stall;
      repeat (count) begin
         r       = $urandom_range(0, 99);
         elapsed = 8'($urandom_range(0, 255));
         if (r < 40) begin
            code = REQ_TICK;
            if ($urandom_range(0, 3) != 0) elapsed = 8'($urandom_range(0, 15));
         end else if (r < 52) begin
            code = REQ_START;
         end else if (r < 95) begin
            code = 4'($urandom_range(REQ_STOP, REQ_SUB5));
         end else begin
            code = 4'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
         end
         send(code, elapsed);
      end
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on settings
      send(REQ_TICK, 8'd255);
      send(REQ_UNKNOWN_LO, 8'd0);
      send(REQ_ADD1, 8'd0);
      send(REQ_ADD5, 8'd0);
      send(REQ_SUB1, 8'd0);
      send(REQ_SUB5, 8'd0);
      send(REQ_START, 8'd0);
      send(REQ_TICK, 8'd0);
      send(REQ_TICK, 8'd1);
      send(REQ_TOGGLE, 8'd0);
      send(REQ_TICK, 8'd5);
      send(REQ_TOGGLE, 8'd0);
      send(REQ_TICK, 8'd255);
      send(REQ_TICK, 8'd200);
      send(REQ_STOP, 8'd0);
      send(REQ_RELOAD, 8'd0);
      send(REQ_UNKNOWN_HI, 8'd170);
      drain();

      // zero reload and zero ceiling
      set_config('0, '0);
      send(REQ_RELOAD, 8'd0);
      send(REQ_ADD1, 8'd0);
      send(REQ_SUB5, 8'd0);
      send(REQ_START, 8'd0);
      send(REQ_TICK, 8'd0);
      drain();

      // one-hour reload wraps the minutes
      set_config(HOUR_SECS, HOUR_SECS);
      send(REQ_RELOAD, 8'd0);
      send(REQ_ADD1, 8'd0);
      send(REQ_SUB1, 8'd0);
      send(REQ_START, 8'd0);
      send(REQ_TICK, 8'd85);
      drain();

      set_config(CSR_BITS'($urandom_range(60, 3600)), HOUR_SECS);
      hold_left = 80;
      run_phase(110, 0, 0);

      set_config(HOUR_SECS, CSR_BITS'($urandom_range(0, 3600)));
      run_phase(110, 46, 0);

      set_config(CSR_BITS'($urandom_range(0, 3600)), CSR_BITS'($urandom_range(0, 3600)));
      run_phase(110, 0, 46);

      set_config(CSR_BITS'($urandom_range(0, 600)), CSR_BITS'($urandom_range(0, 3600)));
      run_phase(110, 16, 16);

      $display("Covered %0d commands, %0d results checked, %0d register writes,",
               items_sent, results_seen, csr_writes);
      $display("all command codes, zero and one-hour limits, and four idle/stall mixes.");
      if (fail_count == 0 && drain_fail == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
